FILE: rtl/core/qspt_pkg.sv
package qspt_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = AW + 1;
    localparam int QD    = 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TASK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_SYNC  = 2'd1,
        KIND_CHILD = 2'd2,
        KIND_READY = 2'd3
    } t_kind;

    // One classified request as it travels from front to back.
    typedef struct packed {
        t_cmd          cmd;
        logic [AW-1:0] idx;
        logic [31:0]   val;
        logic [AW-1:0] lo;
        logic [EW-1:0] hi;
        logic          empty;
        logic [63:0]   pcont;
        logic [63:0]   clos;
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE, S_RDW, S_PIV, S_PIVW, S_RLO, S_RLOW, S_CMP,
        S_SWR, S_SWW, S_PSW, S_PSW2, S_E0, S_E1, S_E2
    } t_state;

endpackage

FILE: rtl/core/quicksort_partition_task_unit.sv
// Channel   Handshake            Payload
// request   i_valid / o_ready    i_command .. i_closure_addr
// result    o_valid / i_ready    o_kind .. o_last
//
// A write completes in the back end's idle state; a read adds a wait state.
// A task reads, waits and compares per forward step and adds the swap states
// per swap over its range, paced by the one read port and one write port of
// the element store, plus pivot fetch, pivot swap and result issue states.
// Reset clears control only; the element store holds garbage until written.
// A two-entry request queue lets requests arrive while the back end stalls.
module quicksort_partition_task_unit import qspt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_elem_index,
    input  logic [31:0] i_elem_value,
    input  logic [9:0]  i_range_begin,
    input  logic [10:0] i_range_end,
    input  logic [63:0] i_parent_cont,
    input  logic [63:0] i_closure_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_read_value,
    output logic [10:0] o_child_begin,
    output logic [10:0] o_child_end,
    output logic [63:0] o_cont_out,
    output logic [63:0] o_sync_closure,
    output logic [1:0]  o_child_count,
    output logic        o_last
);
    logic w_qv, w_qr;
    t_req w_qreq;

    qspt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_command, .i_elem_index, .i_elem_value, .i_range_begin, .i_range_end,
        .i_parent_cont, .i_closure_addr,
        .o_q_valid(w_qv), .i_q_ready(w_qr), .o_q_req(w_qreq)
    );

    qspt_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_qv), .o_q_ready(w_qr), .i_q_req(w_qreq),
        .o_valid, .i_ready, .o_kind, .o_read_value, .o_child_begin,
        .o_child_end, .o_cont_out, .o_sync_closure, .o_child_count, .o_last
    );
endmodule

FILE: rtl/core/qspt_front.sv
module qspt_front import qspt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_elem_index,
    input  logic [31:0] i_elem_value,
    input  logic [9:0]  i_range_begin,
    input  logic [10:0] i_range_end,
    input  logic [63:0] i_parent_cont,
    input  logic [63:0] i_closure_addr,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_req        o_q_req
);
    t_req             r_q [QD];
    logic [1:0]       r_wp, r_rp, r_cnt;
    t_req             w_req;
    logic [EW-1:0]    w_end;
    logic             w_push, w_pop;

    // Classify the request: clamp the end and flag an empty range.
    always_comb begin
        w_end       = (i_range_end > 11'(DEPTH)) ? EW'(DEPTH) : EW'(i_range_end);
        w_req.cmd   = t_cmd'(i_command);
        w_req.idx   = AW'(i_elem_index);
        w_req.val   = i_elem_value;
        w_req.lo    = AW'(i_range_begin);
        w_req.hi    = w_end;
        w_req.empty = EW'(i_range_begin) >= w_end;
        w_req.pcont = i_parent_cont;
        w_req.clos  = i_closure_addr;
    end

    assign o_ready   = r_cnt != 2'(QD);
    assign w_push    = i_valid && o_ready && (i_command != CMD_NONE);
    assign o_q_valid = r_cnt != 2'd0;
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_req   = r_q[r_rp[0]];

    // Two-entry queue between the front and the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp[0]] <= w_req;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QD))
        else $error("queue count overflow");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_q_valid) else $error("pop from empty queue");
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count slip");
endmodule

FILE: rtl/core/qspt_back.sv
module qspt_back import qspt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_req        i_q_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_read_value,
    output logic [10:0] o_child_begin,
    output logic [10:0] o_child_end,
    output logic [63:0] o_cont_out,
    output logic [63:0] o_sync_closure,
    output logic [1:0]  o_child_count,
    output logic        o_last
);
    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd;
    t_state        r_st, n_st;
    t_req          r_req;
    logic [AW-1:0] r_lo, r_hi, r_p;
    logic [31:0]   r_piv, r_vlo, r_vhi;
    // Output register.
    logic          r_ov;
    logic [1:0]    r_kind, r_cnt;
    logic [31:0]   r_rv;
    logic [10:0]   r_cb, r_ce;
    logic [63:0]   r_co, r_sc;
    logic          r_last;

    logic          w_we;
    logic [AW-1:0] w_wa, w_ra;
    logic [31:0]   w_wd;
    logic          w_up, w_dn, w_oa;
    logic [1:0]    w_nc;

    assign w_oa = !r_ov || i_ready;
    assign w_up = (EW'(r_hi) + EW'(1)) < r_req.hi;
    assign w_dn = r_req.lo < r_hi;
    assign w_nc = 2'(w_up) + 2'(w_dn);
    assign o_q_ready = (r_st == S_IDLE);

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_q_valid) begin
                unique case (i_q_req.cmd)
                    CMD_WRITE: n_st = S_IDLE;
                    CMD_READ:  n_st = S_RDW;
                    default:   n_st = i_q_req.empty ? S_E0 : S_PIV;
                endcase
            end
            S_RDW:  if (w_oa) n_st = S_IDLE;
            S_PIV:  n_st = S_PIVW;
            S_PIVW: n_st = S_RLO;
            S_RLO:  n_st = (r_lo < r_hi) ? S_RLOW : S_PSW;
            S_RLOW: n_st = S_CMP;
            S_CMP:  n_st = ($signed(r_vlo) < $signed(r_piv)) ? S_RLO : S_SWR;
            S_SWR:  n_st = S_SWW;
            S_SWW:  n_st = S_RLO;
            S_PSW:  n_st = S_PSW2;
            S_PSW2: n_st = S_E0;
            S_E0:   if (w_oa) n_st = S_E1;
            S_E1:   if (w_oa) n_st = (r_req.empty || w_nc != 2'd2) ? S_IDLE : S_E2;
            S_E2:   if (w_oa) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_lo;
        w_wd = r_vhi;
        w_ra = r_lo;
        unique case (r_st)
            S_IDLE: begin
                w_we = i_q_valid && i_q_req.cmd == CMD_WRITE;
                w_wa = i_q_req.idx;
                w_wd = i_q_req.val;
                w_ra = i_q_req.idx;
            end
            // Keep the read data stable while the result waits.
            S_RDW:  w_ra = r_req.idx;
            S_PIV:  w_ra = r_p;
            // Fetch the next lower element, or the upper element to swap.
            S_CMP:  w_ra = ($signed(r_vlo) < $signed(r_piv)) ? r_lo + AW'(1)
                                                              : r_hi - AW'(1);
            S_SWW: begin
                w_we = 1'b1; w_wa = r_hi; w_wd = r_vlo;
            end
            S_SWR: begin
                w_we = 1'b1; w_wa = r_lo; w_wd = r_rd;
            end
            S_PSW: begin
                w_we = 1'b1; w_wa = r_p; w_wd = r_vhi; w_ra = r_hi;
            end
            S_PSW2: begin
                w_we = 1'b1; w_wa = r_hi; w_wd = r_piv;
            end
            default: ;
        endcase
    end

    // Element store.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: if (i_q_valid) begin
                r_req <= i_q_req;
                r_lo  <= i_q_req.lo;
                r_hi  <= AW'(i_q_req.hi - EW'(1));
                r_p   <= AW'(i_q_req.hi - EW'(1));
            end
            S_PIVW: r_piv <= r_rd;
            S_RLOW: r_vlo <= r_rd;
            S_CMP: begin
                if ($signed(r_vlo) < $signed(r_piv)) r_lo <= r_lo + AW'(1);
                else r_hi <= r_hi - AW'(1);
            end
            S_SWR:  r_vhi <= r_rd;
            S_RLO:  r_vhi <= r_rd;
            S_PSW2: r_vhi <= r_rd;
            default: ;
        endcase
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_ready) r_ov <= 1'b0;
            if (w_oa && (r_st == S_RDW || r_st == S_E0 || r_st == S_E1 || r_st == S_E2))
                r_ov <= 1'b1;
        end
        if (w_oa) begin
            r_rv <= '0; r_cb <= '0; r_ce <= '0; r_co <= '0; r_sc <= '0;
            r_cnt <= '0; r_last <= 1'b0; r_kind <= KIND_READ;
            unique case (r_st)
                S_RDW: begin
                    r_rv <= r_rd; r_last <= 1'b1;
                end
                S_E0: begin
                    r_kind <= KIND_SYNC; r_co <= r_req.pcont; r_sc <= r_req.clos;
                    r_cnt <= r_req.empty ? 2'd0 : w_nc;
                end
                S_E1: begin
                    if (r_req.empty || w_nc == 2'd0) begin
                        r_kind <= KIND_READY; r_co <= r_req.pcont; r_last <= 1'b1;
                    end else begin
                        r_kind <= KIND_CHILD; r_co <= r_req.clos;
                        r_last <= (w_nc == 2'd1);
                        if (w_up) begin
                            r_cb <= 11'(r_hi) + 11'd1; r_ce <= 11'(r_req.hi);
                        end else begin
                            r_cb <= 11'(r_req.lo); r_ce <= 11'(r_hi);
                        end
                    end
                end
                S_E2: begin
                    r_kind <= KIND_CHILD; r_co <= r_req.clos; r_last <= 1'b1;
                    r_cb <= 11'(r_req.lo); r_ce <= 11'(r_hi);
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_read_value   = r_rv;
    assign o_child_begin  = r_cb;
    assign o_child_end    = r_ce;
    assign o_cont_out     = r_co;
    assign o_sync_closure = r_sc;
    assign o_child_count  = r_cnt;
    assign o_last         = r_last;

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CMP) |-> r_lo < r_hi) else $error("index crossing");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_q_ready) else $error("took request while busy");
endmodule

FILE: dv/tb_top.sv
module tb_top;
    import qspt_pkg::*;

    // One expected result record.
    typedef struct {
        t_kind       kind;
        logic [31:0] read_value;
        logic [10:0] child_begin;
        logic [10:0] child_end;
        logic [63:0] cont_out;
        logic [63:0] sync_closure;
        logic [1:0]  child_count;
        logic        last;
    } t_result;

    // Predicts results from a private copy of the element store and checks them in order.
    class partition_scoreboard;
        logic [31:0] store[DEPTH];
        t_result     pending[$];
        int          errors;

        function void push(t_kind k, logic [31:0] rv, logic [10:0] cb, logic [10:0] ce,
                           logic [63:0] co, logic [63:0] sc, logic [1:0] cc);
            t_result r;
            r.kind = k; r.read_value = rv; r.child_begin = cb; r.child_end = ce;
            r.cont_out = co; r.sync_closure = sc; r.child_count = cc; r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_request(t_cmd cmd, logic [9:0] idx, logic [31:0] val,
                                   logic [9:0] rb, logic [10:0] re,
                                   logic [63:0] pc, logic [63:0] ca);
            int lo, hi, p, mid, e;
            logic [31:0] pivot, t;
            bit up, down;
            logic [1:0] cnt;
            case (cmd)
                CMD_WRITE: store[idx] = val;
                CMD_READ: begin
                    push(KIND_READ, store[idx], 0, 0, 0, 0, 0);
                    pending[$].last = 1'b1;
                end
                CMD_TASK: begin
                    e = (re > DEPTH) ? DEPTH : re;
                    if (rb >= e) begin
                        push(KIND_SYNC, 0, 0, 0, pc, ca, 0);
                        push(KIND_READY, 0, 0, 0, pc, 0, 0);
                    end else begin
                        p = e - 1;
                        pivot = store[p];
                        lo = rb;
                        hi = p;
                        while (lo < hi) begin
                            if ($signed(store[lo]) < $signed(pivot)) begin
                                lo++;
                            end else begin
                                hi--;
                                t = store[lo]; store[lo] = store[hi]; store[hi] = t;
                            end
                        end
                        mid = hi;
                        t = store[p]; store[p] = store[mid]; store[mid] = t;
                        up = (mid + 1 < e);
                        down = (rb < mid);
                        cnt = up + down;
                        push(KIND_SYNC, 0, 0, 0, pc, ca, cnt);
                        if (up) push(KIND_CHILD, 0, mid + 1, e, ca, 0, 0);
                        if (down) push(KIND_CHILD, 0, rb, mid, ca, 0, 0);
                        if (cnt == 0) push(KIND_READY, 0, 0, 0, pc, 0, 0);
                    end
                    pending[$].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result x;
            if (pending.size() == 0) begin
                $error("unexpected result kind=%0d", got.kind);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.kind !== x.kind) begin
                $error("kind: expected %0d actual %0d", x.kind, got.kind); errors++;
            end
            if (got.read_value !== x.read_value) begin
                $error("read_value: expected %0d actual %0d",
                       $signed(x.read_value), $signed(got.read_value)); errors++;
            end
            if (got.child_begin !== x.child_begin) begin
                $error("child_begin: expected %0d actual %0d", x.child_begin,
                       got.child_begin); errors++;
            end
            if (got.child_end !== x.child_end) begin
                $error("child_end: expected %0d actual %0d", x.child_end,
                       got.child_end); errors++;
            end
            if (got.cont_out !== x.cont_out) begin
                $error("cont_out: expected %h actual %h", x.cont_out, got.cont_out); errors++;
            end
            if (got.sync_closure !== x.sync_closure) begin
                $error("sync_closure: expected %h actual %h", x.sync_closure,
                       got.sync_closure); errors++;
            end
            if (got.child_count !== x.child_count) begin
                $error("child_count: expected %0d actual %0d", x.child_count,
                       got.child_count); errors++;
            end
            if (got.last !== x.last) begin
                $error("last: expected %0d actual %0d", x.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_WRITE;
    logic [9:0]  i_elem_index = '0;
    logic [31:0] i_elem_value = '0;
    logic [9:0]  i_range_begin = '0;
    logic [10:0] i_range_end = '0;
    logic [63:0] i_parent_cont = '0;
    logic [63:0] i_closure_addr = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_read_value;
    logic [10:0] o_child_begin;
    logic [10:0] o_child_end;
    logic [63:0] o_cont_out;
    logic [63:0] o_sync_closure;
    logic [1:0]  o_child_count;
    logic        o_last;

    quicksort_partition_task_unit dut (.*);

    partition_scoreboard sb = new();
    bit written[DEPTH];
    bit quiet_phase = 1'b0;
    bit stim_done = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sends one request, with an occasional idle burst ahead of it.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(t_cmd cmd, logic [9:0] idx, logic [31:0] val,
                                logic [9:0] rb, logic [10:0] re,
                                logic [63:0] pc, logic [63:0] ca);
        int gap;
        if (!quiet_phase && $urandom_range(3) == 0) begin
            gap = $urandom_range(16, 1);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_elem_index <= idx;
        i_elem_value <= val;
        i_range_begin <= rb;
        i_range_end <= re;
        i_parent_cont <= pc;
        i_closure_addr <= ca;
        do @(posedge i_clk); while (!o_ready);
        if (cmd == CMD_WRITE) written[idx] = 1'b1;
        sb.note_request(cmd, idx, val, rb, re, pc, ca);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7);
            default: return $urandom();
        endcase
    endfunction

    // Task over a fully written range; mostly small ranges, rarely large ones.
    task automatic send_task();
        int len, b;
        len = ($urandom_range(19) == 0) ? $urandom_range(120, 1) : $urandom_range(12, 1);
        b = $urandom_range(128 - len);
        for (int k = b; k < b + len; k++)
            if (!written[k]) send_request(CMD_WRITE, k, rand_value(), 0, 0, 0, 0);
        send_request(CMD_TASK, $urandom(), $urandom(), b, b + len, rand64(), rand64());
    endtask

    // Result side: random ready bursts, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_valid && i_ready) begin
            r.kind = t_kind'(o_kind); r.read_value = o_read_value;
            r.child_begin = o_child_begin; r.child_end = o_child_end;
            r.cont_out = o_cont_out; r.sync_closure = o_sync_closure;
            r.child_count = o_child_count; r.last = o_last;
            sb.check_result(r);
        end
    end

    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (quiet_phase) begin
                i_ready <= 1'b1;
            end else begin
                burst = $urandom_range(16, 1);
                i_ready <= $urandom_range(1);
                repeat (burst - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, every command, unused command, empty and clamped ranges.
        send_request(CMD_WRITE, 0, 32'h8000_0000, 0, 0, 0, 0);
        send_request(CMD_WRITE, 1023, 32'h7fff_ffff, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0);
        send_request(CMD_READ, 1023, 32'hffff_ffff, 10'h3ff, 11'h7ff, '1, '1);
        send_request(CMD_NONE, 10'h3ff, '1, 10'h3ff, 11'h7ff, '1, '1);
        send_request(CMD_TASK, 0, 0, 1023, 1024, 64'hffff_ffff_ffff_ffff, 0);
        send_request(CMD_TASK, 0, 0, 1023, 11'h7ff, 0, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_TASK, 0, 0, 10'h3ff, 11'h400, 64'h5555, 64'haaaa);
        send_request(CMD_TASK, 0, 0, 5, 5, 64'h1234, 64'h5678);
        send_request(CMD_TASK, 0, 0, 10'h3ff, 11'h401, 64'h1, 64'h2);
        send_request(CMD_TASK, 0, 0, 700, 3, 64'h3, 64'h4);
        for (int k = 1; k < 6; k++) send_request(CMD_WRITE, k, 6 - k, 0, 0, 0, 0);
        send_request(CMD_TASK, 0, 0, 0, 6, rand64(), rand64());
        for (int k = 10; k < 14; k++) send_request(CMD_WRITE, k, 32'd7, 0, 0, 0, 0);
        send_request(CMD_TASK, 0, 0, 10, 14, rand64(), rand64());
        send_request(CMD_READ, 12, 0, 0, 0, 0, 0);

        // Random: mostly tasks over written ranges, with reads, writes and noise.
        for (int n = 0; n < 150; n++) begin
            int idx;
            if (n == 125) quiet_phase = 1'b1;
            case ($urandom_range(9))
                0, 1: send_request(CMD_WRITE, $urandom(), rand_value(), $urandom(),
                                   $urandom(), rand64(), rand64());
                2: begin
                    idx = $urandom_range(DEPTH - 1);
                    if (!written[idx]) idx = 0;
                    send_request(CMD_READ, idx, $urandom(), $urandom(), $urandom(),
                                 rand64(), rand64());
                end
                3: send_request(CMD_NONE, $urandom(), $urandom(), $urandom(),
                                $urandom(), rand64(), rand64());
                4: send_request(CMD_TASK, $urandom(), $urandom(),
                                10'($urandom_range(1023, 16)),
                                $urandom_range(1023, 0) & 11'h00f, rand64(), rand64());
                default: send_task();
            endcase
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end
endmodule
